FILE: sv/ifu_pkg.sv
// ----------------------------------------------------------------------------
// Integer-factor upscaler package
// Shared types, field widths, register indexes and the reciprocal table
// used by the controller and datapath.
// ----------------------------------------------------------------------------
package ifu_pkg;

   localparam int PIX_W    = 8;
   localparam int COORD_W  = 13;
   localparam int FACT_W   = 4;
   localparam int DIM_W    = 11;
   localparam int CSR_IX_W = 2;

   // register indexes
   localparam logic [CSR_IX_W-1:0] CSR_SCALE = 2'd0;
   localparam logic [CSR_IX_W-1:0] CSR_MODE  = 2'd1;
   localparam logic [CSR_IX_W-1:0] CSR_ROWS  = 2'd2;
   localparam logic [CSR_IX_W-1:0] CSR_COLS  = 2'd3;

   // interpolation modes
   localparam logic MODE_NEAREST  = 1'b0;
   localparam logic MODE_BILINEAR = 1'b1;

   // divide by f*f as multiply by ceil(2^RECIP_SHIFT / (f*f))
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_W     = RECIP_SHIFT + 1;

   typedef struct packed {
      logic accept;  // item taken this cycle
      logic look;    // line store data valid, latch edge pixels
      logic issue;   // launch one output pixel into the pipeline
   } ifu_cmd_type;

   typedef struct packed {
      logic has_cell;   // current item produces a cell
      logic cell_done;  // pixel counters sit on the last pixel of the cell
      logic adv;        // pipeline may move
   } ifu_sts_type;

   function automatic logic [RECIP_W-1:0] recip_of(input logic [FACT_W-1:0] f);
      logic [RECIP_W-1:0] r;
      unique case (f)
         4'd2:    r = RECIP_W'(262144);
         4'd3:    r = RECIP_W'(116509);
         4'd4:    r = RECIP_W'(65536);
         4'd5:    r = RECIP_W'(41944);
         4'd6:    r = RECIP_W'(29128);
         4'd7:    r = RECIP_W'(21400);
         4'd8:    r = RECIP_W'(16384);
         default: r = RECIP_W'(1048576);
      endcase
      return r;
   endfunction

endpackage

FILE: sv/ifu_ctrl.sv
// ----------------------------------------------------------------------------
// Upscaler controller
// Sequences one item: accept, line store read, then one output pixel
// issued per free pipeline cycle until the cell is complete.
// ----------------------------------------------------------------------------
module ifu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ifu_pkg::ifu_sts_type sts,
   output ifu_pkg::ifu_cmd_type cmd
);
   import ifu_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOOK = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // commands
   assign req_ready  = (state_ff == ST_IDLE);
   assign cmd.accept = req_ready && req_valid;
   assign cmd.look   = (state_ff == ST_LOOK);
   assign cmd.issue  = (state_ff == ST_EMIT) && sts.adv;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_LOOK;
         ST_LOOK: state_in = sts.has_cell ? ST_EMIT : ST_IDLE;
         ST_EMIT: if (sts.adv && sts.cell_done) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

FILE: sv/ifu_datapath.sv
// ----------------------------------------------------------------------------
// Upscaler datapath
// Position counters, line store, edge pixels, cell pixel counters and a
// four-stage blend pipeline ending in the result register.
// ----------------------------------------------------------------------------
module ifu_datapath #(
   parameter int MAX_COLS   = 1024,
   parameter int MAX_ROWS   = 1024,
   parameter int MAX_FACTOR = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ifu_pkg::ifu_cmd_type          cmd,
   output ifu_pkg::ifu_sts_type          sts,
   input  logic [ifu_pkg::PIX_W-1:0]     req_pixel,
   input  logic [ifu_pkg::FACT_W-1:0]    cfg_scale,
   input  logic                          cfg_mode,
   input  logic [ifu_pkg::DIM_W-1:0]     cfg_rows,
   input  logic [ifu_pkg::DIM_W-1:0]     cfg_cols,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ifu_pkg::COORD_W-1:0]   rsp_out_row,
   output logic [ifu_pkg::COORD_W-1:0]   rsp_out_col,
   output logic [ifu_pkg::PIX_W-1:0]     rsp_value,
   output logic                          rsp_cell_last
);
   import ifu_pkg::*;

   localparam int CC_W = $clog2(MAX_COLS);
   localparam int CL_W = CC_W + 1;
   localparam int RC_W = $clog2(MAX_ROWS);
   localparam int RL_W = RC_W + 1;
   localparam int EDGE_W = 11;   // (f-j)*A + j*C <= 8*255
   localparam int SUM_W  = 14;   // full weighted sum <= 64*255
   localparam int DEN_W  = 7;

   // effective configuration
   logic [FACT_W-1:0] f_eff;
   logic [RL_W-1:0]   rows_lim;
   logic [CL_W-1:0]   cols_lim;
   logic [DEN_W-1:0]  den;

   always_comb begin
      if (cfg_scale == '0)                   f_eff = FACT_W'(1);
      else if (int'(cfg_scale) > MAX_FACTOR) f_eff = FACT_W'(MAX_FACTOR);
      else                                   f_eff = cfg_scale;
      if (int'(cfg_rows) < 2)                rows_lim = RL_W'(2);
      else if (int'(cfg_rows) > MAX_ROWS)    rows_lim = RL_W'(MAX_ROWS);
      else                                   rows_lim = RL_W'(cfg_rows);
      if (int'(cfg_cols) < 2)                cols_lim = CL_W'(2);
      else if (int'(cfg_cols) > MAX_COLS)    cols_lim = CL_W'(MAX_COLS);
      else                                   cols_lim = CL_W'(cfg_cols);
   end
   assign den = DEN_W'(f_eff) * DEN_W'(f_eff);

   // position of the item, wrapped for any size change, and next position
   logic [RC_W-1:0] row_ff, row_in;
   logic [CC_W-1:0] col_ff, col_in;
   logic            col_wrap;
   logic [RL_W-1:0] r_step, r_next;
   logic [RC_W-1:0] r0;
   logic [CC_W-1:0] c0;
   logic [CL_W-1:0] c_next;

   always_comb begin
      col_wrap = {1'b0, col_ff} >= cols_lim;
      c0       = col_wrap ? '0 : col_ff;
      r_step   = {1'b0, row_ff} + (col_wrap ? RL_W'(1) : RL_W'(0));
      r0       = (r_step >= rows_lim) ? '0 : r_step[RC_W-1:0];
      c_next   = {1'b0, c0} + CL_W'(1);
      r_next   = {1'b0, r0} + RL_W'(1);
      if (c_next >= cols_lim) begin
         col_in = '0;
         row_in = (r_next >= rows_lim) ? '0 : r_next[RC_W-1:0];
      end else begin
         col_in = c_next[CC_W-1:0];
         row_in = r0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (cmd.accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // line store, read before write
   logic [PIX_W-1:0] line_mem [MAX_COLS];
   logic [PIX_W-1:0] above_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         line_mem[c0] <= req_pixel;
         above_ff     <= line_mem[c0];
      end
   end

   // edge pixels
   logic [PIX_W-1:0] left_ff, above_left_ff;
   logic [PIX_W-1:0] a_ff, b_ff, d_ff;
   logic [RC_W-1:0]  r_ff;
   logic [CC_W-1:0]  c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff       <= '0;
         above_left_ff <= '0;
      end else begin
         if (cmd.accept) left_ff       <= req_pixel;
         if (cmd.look)   above_left_ff <= above_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         a_ff <= above_left_ff;
         b_ff <= left_ff;
         d_ff <= req_pixel;
         r_ff <= r0;
         c_ff <= c0;
      end
   end

   // cell origin in the enlarged image
   logic [COORD_W-1:0] row_base_ff, col_base_ff;

   always_ff @(posedge clock) begin
      if (cmd.look) begin
         row_base_ff <= COORD_W'(r_ff - RC_W'(1)) * COORD_W'(f_eff);
         col_base_ff <= COORD_W'(c_ff - CC_W'(1)) * COORD_W'(f_eff);
      end
   end

   // pixel counters within the cell
   logic [FACT_W-1:0] i_ff, j_ff;
   logic              last_j;

   assign last_j = (j_ff == f_eff - FACT_W'(1));

   always_ff @(posedge clock) begin
      if (cmd.look) begin
         i_ff <= '0;
         j_ff <= '0;
      end else if (cmd.issue) begin
         if (last_j) begin
            j_ff <= '0;
            i_ff <= i_ff + FACT_W'(1);
         end else begin
            j_ff <= j_ff + FACT_W'(1);
         end
      end
   end

   logic adv;
   assign adv = !rsp_valid || rsp_ready;

   assign sts.has_cell  = (r_ff != '0) && (c_ff != '0);
   assign sts.cell_done = last_j && (i_ff == f_eff - FACT_W'(1));
   assign sts.adv       = adv;

   // stage 1: column blends and nearest pick
   logic               v1_ff;
   logic [EDGE_W-1:0]  top1_ff, bot1_ff;
   logic [FACT_W-1:0]  fi1_ff, i1_ff;
   logic [PIX_W-1:0]   near1_ff;
   logic [COORD_W-1:0] row1_ff, col1_ff;
   logic               last1_ff;
   logic [FACT_W-1:0]  fj;
   logic               down, right;
   logic [PIX_W-1:0]   near_sel;

   always_comb begin
      fj       = f_eff - j_ff;
      down     = {i_ff, 1'b0} >= {1'b0, f_eff};
      right    = {j_ff, 1'b0} >= {1'b0, f_eff};
      near_sel = down ? (right ? d_ff : b_ff) : (right ? above_ff : a_ff);
   end

   always_ff @(posedge clock) begin
      if (reset)    v1_ff <= 1'b0;
      else if (adv) v1_ff <= cmd.issue;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         top1_ff  <= EDGE_W'(fj) * EDGE_W'(a_ff) + EDGE_W'(j_ff) * EDGE_W'(above_ff);
         bot1_ff  <= EDGE_W'(fj) * EDGE_W'(b_ff) + EDGE_W'(j_ff) * EDGE_W'(d_ff);
         fi1_ff   <= f_eff - i_ff;
         i1_ff    <= i_ff;
         near1_ff <= near_sel;
         row1_ff  <= row_base_ff + COORD_W'(i_ff);
         col1_ff  <= col_base_ff + COORD_W'(j_ff);
         last1_ff <= sts.cell_done;
      end
   end

   // stage 2: row blend
   logic               v2_ff;
   logic [SUM_W-1:0]   s2_ff;
   logic [PIX_W-1:0]   near2_ff;
   logic [COORD_W-1:0] row2_ff, col2_ff;
   logic               last2_ff;

   always_ff @(posedge clock) begin
      if (reset)    v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ff    <= SUM_W'(fi1_ff) * SUM_W'(top1_ff) + SUM_W'(i1_ff) * SUM_W'(bot1_ff);
         near2_ff <= near1_ff;
         row2_ff  <= row1_ff;
         col2_ff  <= col1_ff;
         last2_ff <= last1_ff;
      end
   end

   // stage 3: truncated quotient by reciprocal multiply
   logic                     v3_ff;
   logic [SUM_W-1:0]         s3_ff;
   logic [PIX_W-1:0]         q3_ff, near3_ff;
   logic [COORD_W-1:0]       row3_ff, col3_ff;
   logic                     last3_ff;
   logic [SUM_W+RECIP_W-1:0] prod;

   assign prod = s2_ff * recip_of(f_eff);

   always_ff @(posedge clock) begin
      if (reset)    v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_ff    <= s2_ff;
         q3_ff    <= prod[RECIP_SHIFT +: PIX_W];
         near3_ff <= near2_ff;
         row3_ff  <= row2_ff;
         col3_ff  <= col2_ff;
         last3_ff <= last2_ff;
      end
   end

   // stage 4: remainder, round half to even, result register
   logic [SUM_W-1:0] qd, rem_full;
   logic [DEN_W-1:0] rem;
   logic [DEN_W:0]   rem2;
   logic             up;
   logic [PIX_W-1:0] blend_val;

   always_comb begin
      qd        = SUM_W'(q3_ff) * SUM_W'(den);
      rem_full  = s3_ff - qd;
      rem       = rem_full[DEN_W-1:0];
      rem2      = {rem, 1'b0};
      up        = (rem2 > {1'b0, den}) || ((rem2 == {1'b0, den}) && q3_ff[0]);
      blend_val = q3_ff + PIX_W'(up);
   end

   always_ff @(posedge clock) begin
      if (reset)    rsp_valid <= 1'b0;
      else if (adv) rsp_valid <= v3_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_value     <= (cfg_mode == MODE_BILINEAR) ? blend_val : near3_ff;
         rsp_out_row   <= row3_ff;
         rsp_out_col   <= col3_ff;
         rsp_cell_last <= last3_ff;
      end
   end

endmodule

FILE: sv/integer_factor_image_upscaler_top.sv
// ----------------------------------------------------------------------------
// Integer-factor image upscaler, top level
// Flow: an accepted item goes through the line store read, then the emit
//   sequencer issues one output pixel per cycle while the pipeline may advance;
//   input is held until the cell is complete, or the item makes no cell.
// Reset (synchronous): position counters, left and above-left edge pixels and
//   pipeline valids cleared, registers to defaults; the line store is not cleared.
// ----------------------------------------------------------------------------
module integer_factor_image_upscaler_top #(
   parameter int MAX_COLS   = 1024,
   parameter int MAX_ROWS   = 1024,
   parameter int MAX_FACTOR = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ifu_pkg::PIX_W-1:0]       req_pixel,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ifu_pkg::COORD_W-1:0]     rsp_out_row,
   output logic [ifu_pkg::COORD_W-1:0]     rsp_out_col,
   output logic [ifu_pkg::PIX_W-1:0]       rsp_value,
   output logic                            rsp_cell_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ifu_pkg::CSR_IX_W-1:0]    csr_index,
   input  logic [ifu_pkg::DIM_W-1:0]       csr_wdata
);
   import ifu_pkg::*;

   // configuration registers
   logic [FACT_W-1:0] scale_ff;
   logic              mode_ff;
   logic [DIM_W-1:0]  rows_ff, cols_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= FACT_W'(2);
         mode_ff  <= MODE_BILINEAR;
         rows_ff  <= DIM_W'(1024);
         cols_ff  <= DIM_W'(1024);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SCALE: scale_ff <= csr_wdata[FACT_W-1:0];
            CSR_MODE:  mode_ff  <= csr_wdata[0];
            CSR_ROWS:  rows_ff  <= csr_wdata;
            CSR_COLS:  cols_ff  <= csr_wdata;
            default:   ;
         endcase
      end
   end

   ifu_cmd_type cmd;
   ifu_sts_type sts;

   ifu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ifu_datapath #(
      .MAX_COLS   (MAX_COLS),
      .MAX_ROWS   (MAX_ROWS),
      .MAX_FACTOR (MAX_FACTOR)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_pixel     (req_pixel),
      .cfg_scale     (scale_ff),
      .cfg_mode      (mode_ff),
      .cfg_rows      (rows_ff),
      .cfg_cols      (cols_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_value     (rsp_value),
      .rsp_cell_last (rsp_cell_last)
   );

   // an accepted item always reads the line store in the next cycle
   a_accept_look: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> cmd.look)
      else $error("line store read did not follow accept");

   // no pixel issue while a new item is being taken
   a_issue_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.accept && cmd.issue))
      else $error("issue during accept");

   // result register empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule
